// File: design/smao_pkg.sv
// Shared constants, field widths and the stage handoff type for the swerve
// module angle optimizer. No dependencies.
`default_nettype none

package smao_pkg;

	// Steering encoder: counts per turn is a power of two
	localparam int ENC_BITS        = 13;
	localparam int ENCODER_COUNTS  = 1 << ENC_BITS;

	// Angles in hundredths of a degree
	localparam int TURN_CENTI         = 36000;
	localparam int HALF_TURN_CENTI    = 18000;
	localparam int QUARTER_TURN_CENTI = 9000;

	// Field widths
	localparam int TOTAL_W  = 32;
	localparam int TARGET_W = 17;
	localparam int SPEED_W  = 16;
	localparam int ANGLE_W  = 16;   // 0 .. 36000
	localparam int DIFF_W   = 15;   // -9000 .. 9000
	localparam int MAG_W    = 14;   // 0 .. 9000
	localparam int CODE_W   = 12;   // 0 .. 2048 counts of rotation
	localparam int COS_W    = 16;   // Q1.15, 0 .. 32768

	// Cosine table default depth (entries cover 0 .. 90 degrees, plus one)
	localparam int COS_TABLE_DEPTH = 1024;

	// Reciprocal constants for division by a quarter and a full turn
	localparam int RECIP_SHIFT     = 40;
	localparam int RECIP_TURN_W    = 25;
	localparam int RECIP_QUARTER_W = 27;
	localparam logic [RECIP_TURN_W-1:0] RECIP_TURN =
		RECIP_TURN_W'((64'd1 << RECIP_SHIFT) / TURN_CENTI);
	localparam logic [RECIP_QUARTER_W-1:0] RECIP_QUARTER =
		RECIP_QUARTER_W'((64'd1 << RECIP_SHIFT) / QUARTER_TURN_CENTI);

	// Configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_AW-3:0] REG_STEER_OFFSET = '0;

	// Result of the angle pipeline, handed to the output pipeline
	typedef struct packed {
		logic                      valid;
		logic signed [TOTAL_W-1:0] total;
		logic signed [SPEED_W-1:0] spd;
		logic signed [DIFF_W-1:0]  diff;
		logic                      rev;
		logic [CODE_W-1:0]         code;
	} ang_res_t;

endpackage

`default_nettype wire

// File: design/swerve_module_angle_optimizer.sv
// Top level of the swerve module angle optimizer: configuration register, cosine
// table RAM and loader, angle and output pipelines. Uses smao_pkg and all smao_ modules.
//
//   channel   direction  handshake              payload
//   ------------------------------------------------------------------------------
//   request   in         in_valid / in_stall    encoder_angle, encoder_total,
//                                               target_angle, speed_cmd
//   result    out        out_valid / out_stall  steer_code_target, angle_change,
//                                               speed_out, reversed
//   config    in         APB psel/penable/...   steer_offset at byte address 0
//
// One request per clock while in_stall is low; results leave in the order their requests are taken.
// The pipeline has 11 register stages; the cosine lookup is one RAM read in stage 7.
// After reset the cosine table is loaded into the RAM, all COS_TABLE_DEPTH + 1 entries,
// during which in_stall is high; configuration writes are taken as ever.
// While out_valid is high, out_stall holds every stage at once; nothing is dropped or repeated.
`default_nettype none

module swerve_module_angle_optimizer #(
	parameter int COS_TABLE_DEPTH = smao_pkg::COS_TABLE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic        [smao_pkg::CFG_AW-1:0]   paddr,
	input  wire logic        [smao_pkg::CFG_DW-1:0]   pwdata,
	output logic             [smao_pkg::CFG_DW-1:0]   prdata,
	output logic                                      pready,

	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [smao_pkg::ENC_BITS-1:0] encoder_angle,
	input  wire logic signed [smao_pkg::TOTAL_W-1:0]  encoder_total,
	input  wire logic signed [smao_pkg::TARGET_W-1:0] target_angle,
	input  wire logic signed [smao_pkg::SPEED_W-1:0]  speed_cmd,

	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [smao_pkg::TOTAL_W-1:0]  steer_code_target,
	output logic signed      [smao_pkg::DIFF_W-1:0]   angle_change,
	output logic signed      [smao_pkg::SPEED_W-1:0]  speed_out,
	output logic                                      reversed
);

	import smao_pkg::*;

	localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);

	// ---------------- configuration register -------------------------------
	logic [ENC_BITS-1:0] steer_offset_q;
	logic [CFG_AW-3:0]   reg_idx;
	logic                cfg_wr;

	assign reg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_offset_q <= '0;
		end else if (cfg_wr && reg_idx == REG_STEER_OFFSET) begin
			steer_offset_q <= pwdata[ENC_BITS-1:0];
		end
	end

	// Read back the register, zero elsewhere
	always_comb begin
		unique case (reg_idx)
			REG_STEER_OFFSET: prdata = CFG_DW'(steer_offset_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- handshake ---------------------------------------------
	logic fill_busy;
	logic en;
	logic take;

	assign en       = ~(out_valid & out_stall);
	assign in_stall = fill_busy | ~en;
	assign take     = in_valid & ~in_stall;

	// ---------------- cosine table ------------------------------------------
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [COS_W-1:0] ram_wdata;
	logic [IDX_W-1:0] cos_idx;
	logic [COS_W-1:0] cos_val;

	smao_cos_init #(
		.COS_DEPTH (COS_TABLE_DEPTH)
	) u_cos_init (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (fill_busy),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata)
	);

	smao_ram #(
		.WIDTH (COS_W),
		.DEPTH (COS_TABLE_DEPTH + 1)
	) u_cos_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (en),
		.raddr (cos_idx),
		.rdata (cos_val)
	);

	// ---------------- pipelines ---------------------------------------------
	ang_res_t ang_res;

	smao_angle_pipe #(
		.COS_DEPTH (COS_TABLE_DEPTH)
	) u_angle_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.take          (take),
		.encoder_angle (encoder_angle),
		.encoder_total (encoder_total),
		.target_angle  (target_angle),
		.speed_cmd     (speed_cmd),
		.steer_offset  (steer_offset_q),
		.res           (ang_res),
		.idx           (cos_idx)
	);

	smao_out_pipe u_out_pipe (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.res               (ang_res),
		.cos_val           (cos_val),
		.out_valid         (out_valid),
		.steer_code_target (steer_code_target),
		.angle_change      (angle_change),
		.speed_out         (speed_out),
		.reversed          (reversed)
	);

endmodule

`default_nettype wire

// File: design/smao_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data and read enable. No dependencies.
`default_nettype none

module smao_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1025
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/smao_cos_init.sv
// Cosine table loader: sweeps the Q1.15 cosine table into the RAM after reset.
// Depends on smao_pkg.
`default_nettype none

module smao_cos_init #(
	parameter int COS_DEPTH = smao_pkg::COS_TABLE_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	output logic                              busy,
	output logic                              we,
	output logic [$clog2(COS_DEPTH+1)-1:0]    waddr,
	output logic [smao_pkg::COS_W-1:0]        wdata
);

	import smao_pkg::*;

	localparam int AW = $clog2(COS_DEPTH + 1);
	localparam longint HALF_PI_Q30 = 64'd1686629713;
	localparam longint ONE_Q30     = 64'd1073741824;
	localparam longint DEPTH_L      = COS_DEPTH;
	localparam longint HALF_DEPTH_L = COS_DEPTH / 2;
	localparam longint TAYLOR_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

	typedef logic [COS_W-1:0] rom_t [COS_DEPTH+1];

	// Taylor series to x^14 in Q30, rounded to Q1.15
	function automatic rom_t build_rom();
		rom_t   rom;
		longint x;
		longint x2;
		longint term;
		longint sum;
		int     i;
		int     k;
		for (i = 0; i <= COS_DEPTH; i++) begin
			x = (longint'(i) * HALF_PI_Q30 + HALF_DEPTH_L) / DEPTH_L;
			x2 = longint'((longint'(unsigned'(x)) * longint'(unsigned'(x))) >>> 30);
			term = ONE_Q30;
			sum = ONE_Q30;
			for (k = 0; k < 7; k++) begin
				term = (term * x2) / ONE_Q30;
				term = -(term / TAYLOR_DIV[k]);
				sum = sum + term;
			end
			if (sum < 0) begin
				sum = 0;
			end
			rom[i] = COS_W'((sum + 64'd16384) >>> 15);
		end
		return rom;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	logic [AW-1:0] cnt_q;
	logic          busy_q;

	// Advance through the table once after reset, then stop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == AW'(COS_DEPTH)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	assign busy  = busy_q;
	assign we    = busy_q;
	assign waddr = cnt_q;
	assign wdata = COS_ROM[cnt_q];

endmodule

`default_nettype wire

// File: design/smao_angle_pipe.sv
// Angle pipeline, stages 1 to 6: present and requested heading, shortest turn
// with reversal, encoder counts of the turn and cosine table index. Uses smao_pkg.
`default_nettype none

module smao_angle_pipe #(
	parameter int COS_DEPTH = smao_pkg::COS_TABLE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 take,
	input  wire logic        [smao_pkg::ENC_BITS-1:0] encoder_angle,
	input  wire logic signed [smao_pkg::TOTAL_W-1:0]  encoder_total,
	input  wire logic signed [smao_pkg::TARGET_W-1:0] target_angle,
	input  wire logic signed [smao_pkg::SPEED_W-1:0]  speed_cmd,
	input  wire logic        [smao_pkg::ENC_BITS-1:0] steer_offset,
	output smao_pkg::ang_res_t                        res,
	output logic             [$clog2(COS_DEPTH+1)-1:0] idx
);

	import smao_pkg::*;

	localparam int IDX_W  = $clog2(COS_DEPTH + 1);
	localparam int PROD_W = ENC_BITS + ANGLE_W;
	localparam int N1_W   = MAG_W + ENC_BITS;
	localparam int N2_W   = MAG_W + IDX_W;
	localparam int P1_W   = N1_W + RECIP_TURN_W;
	localparam int P2_W   = N2_W + RECIP_QUARTER_W;
	localparam int T_W    = TARGET_W + 1;
	localparam int A_W    = ANGLE_W + 1;

	localparam int ENC_ROUND = ENCODER_COUNTS / 2;
	localparam int IDX_ROUND = QUARTER_TURN_CENTI / 2;

	localparam logic signed [T_W-1:0] TURN_T = T_W'(TURN_CENTI);
	localparam logic signed [A_W-1:0] TURN_A = A_W'(TURN_CENTI);

	// ---------------- stage 1: offset, scale, wrap target ----------------
	logic        [ENC_BITS-1:0] d;
	logic signed [T_W-1:0]      t0, t1, t2;

	assign d = encoder_angle - steer_offset;

	always_comb begin
		t0 = T_W'(target_angle);
		t1 = (t0 < 0) ? t0 + TURN_T : t0;
		if (t1 < 0) begin
			t2 = t1 + TURN_T;
		end else if (t1 >= TURN_T) begin
			t2 = t1 - TURN_T;
		end else begin
			t2 = t1;
		end
	end

	logic                      v_s1;
	logic [PROD_W-1:0]         dprod_s1;
	logic [ANGLE_W-1:0]        set_s1;
	logic signed [TOTAL_W-1:0] total_s1;
	logic signed [SPEED_W-1:0] spd_s1;

	// ---------------- stage 2: round heading, opposite heading -------------
	logic [PROD_W-1:0]  cur_raw;
	logic [ANGLE_W-1:0] cur;
	logic [ANGLE_W-1:0] flip;

	always_comb begin
		cur_raw = (dprod_s1 + PROD_W'(ENC_ROUND)) >> ENC_BITS;
		cur = (cur_raw >= PROD_W'(TURN_CENTI)) ? '0 : ANGLE_W'(cur_raw);
		flip = (cur < ANGLE_W'(HALF_TURN_CENTI)) ? cur + ANGLE_W'(HALF_TURN_CENTI)
		                                         : cur - ANGLE_W'(HALF_TURN_CENTI);
	end

	logic                      v_s2;
	logic [ANGLE_W-1:0]        cur_s2;
	logic [ANGLE_W-1:0]        flip_s2;
	logic [ANGLE_W-1:0]        set_s2;
	logic signed [TOTAL_W-1:0] total_s2;
	logic signed [SPEED_W-1:0] spd_s2;

	// ---------------- stage 3: shortest turn and reversal ------------------
	logic signed [A_W-1:0] dc, da, db, cw, ccw, fa, fb, dsel;
	logic                  big;
	logic signed [A_W-1:0] mag_full;

	always_comb begin
		dc  = A_W'(set_s2) - A_W'(cur_s2);
		cw  = (dc < 0) ? dc + TURN_A : dc;
		ccw = TURN_A - cw;
		da  = A_W'(set_s2) - A_W'(flip_s2);
		fa  = (da < 0) ? da + TURN_A : da;
		db  = A_W'(flip_s2) - A_W'(set_s2);
		fb  = (db < 0) ? db + TURN_A : db;
		big = (cw > A_W'(QUARTER_TURN_CENTI)) && (ccw > A_W'(QUARTER_TURN_CENTI));
		if (big) begin
			dsel = (cw > ccw) ? fa : -fb;
		end else begin
			dsel = (ccw < cw) ? -ccw : cw;
		end
		mag_full = (dsel < 0) ? -dsel : dsel;
	end

	logic                      v_s3;
	logic signed [DIFF_W-1:0]  diff_s3;
	logic                      rev_s3;
	logic [MAG_W-1:0]          mag_s3;
	logic signed [TOTAL_W-1:0] total_s3;
	logic signed [SPEED_W-1:0] spd_s3;

	// ---------------- stage 4: rounded numerators --------------------------
	logic [N1_W-1:0] n1;
	logic [N2_W-1:0] n2;

	assign n1 = (N1_W'(mag_s3) << ENC_BITS) + N1_W'(HALF_TURN_CENTI);
	assign n2 = N2_W'(mag_s3) * N2_W'(COS_DEPTH) + N2_W'(IDX_ROUND);

	logic                      v_s4;
	logic [N1_W-1:0]           n1_s4;
	logic [N2_W-1:0]           n2_s4;
	logic signed [DIFF_W-1:0]  diff_s4;
	logic                      rev_s4;
	logic signed [TOTAL_W-1:0] total_s4;
	logic signed [SPEED_W-1:0] spd_s4;

	// ---------------- stage 5: reciprocal quotient estimates ---------------
	logic [P1_W-1:0] p1;
	logic [P2_W-1:0] p2;

	assign p1 = P1_W'(n1_s4) * P1_W'(RECIP_TURN);
	assign p2 = P2_W'(n2_s4) * P2_W'(RECIP_QUARTER);

	logic                      v_s5;
	logic [CODE_W-1:0]         q1_s5;
	logic [IDX_W-1:0]          q2_s5;
	logic [N1_W-1:0]           n1_s5;
	logic [N2_W-1:0]           n2_s5;
	logic signed [DIFF_W-1:0]  diff_s5;
	logic                      rev_s5;
	logic signed [TOTAL_W-1:0] total_s5;
	logic signed [SPEED_W-1:0] spd_s5;

	// ---------------- stage 6: correct estimates by one --------------------
	logic [N1_W-1:0] r1;
	logic [N2_W-1:0] r2;

	assign r1 = n1_s5 - N1_W'(q1_s5) * N1_W'(TURN_CENTI);
	assign r2 = n2_s5 - N2_W'(q2_s5) * N2_W'(QUARTER_TURN_CENTI);

	logic                      v_s6;
	logic [CODE_W-1:0]         code_s6;
	logic [IDX_W-1:0]          idx_s6;
	logic signed [DIFF_W-1:0]  diff_s6;
	logic                      rev_s6;
	logic signed [TOTAL_W-1:0] total_s6;
	logic signed [SPEED_W-1:0] spd_s6;

	// Advance valid bits on enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Advance payload on enable, hold otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s1 <= PROD_W'(d) * PROD_W'(TURN_CENTI);
			set_s1   <= ANGLE_W'(t2);
			total_s1 <= encoder_total;
			spd_s1   <= speed_cmd;

			cur_s2   <= cur;
			flip_s2  <= flip;
			set_s2   <= set_s1;
			total_s2 <= total_s1;
			spd_s2   <= spd_s1;

			diff_s3  <= DIFF_W'(dsel);
			rev_s3   <= big;
			mag_s3   <= MAG_W'(mag_full);
			total_s3 <= total_s2;
			spd_s3   <= spd_s2;

			n1_s4    <= n1;
			n2_s4    <= n2;
			diff_s4  <= diff_s3;
			rev_s4   <= rev_s3;
			total_s4 <= total_s3;
			spd_s4   <= spd_s3;

			q1_s5    <= p1[RECIP_SHIFT +: CODE_W];
			q2_s5    <= p2[RECIP_SHIFT +: IDX_W];
			n1_s5    <= n1_s4;
			n2_s5    <= n2_s4;
			diff_s5  <= diff_s4;
			rev_s5   <= rev_s4;
			total_s5 <= total_s4;
			spd_s5   <= spd_s4;

			code_s6  <= q1_s5 + CODE_W'(r1 >= N1_W'(TURN_CENTI));
			idx_s6   <= q2_s5 + IDX_W'(r2 >= N2_W'(QUARTER_TURN_CENTI));
			diff_s6  <= diff_s5;
			rev_s6   <= rev_s5;
			total_s6 <= total_s5;
			spd_s6   <= spd_s5;
		end
	end

	always_comb begin
		res.valid = v_s6;
		res.total = total_s6;
		res.spd   = spd_s6;
		res.diff  = diff_s6;
		res.rev   = rev_s6;
		res.code  = code_s6;
	end

	assign idx = idx_s6;

endmodule

`default_nettype wire

// File: design/smao_out_pipe.sv
// Output pipeline, stages 7 to 11: saturated encoder target and speed scaled by
// the cube of the cosine, with the result register. Uses smao_pkg.
`default_nettype none

module smao_out_pipe (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire smao_pkg::ang_res_t                  res,
	input  wire logic        [smao_pkg::COS_W-1:0]   cos_val,
	output logic                                     out_valid,
	output logic signed      [smao_pkg::TOTAL_W-1:0] steer_code_target,
	output logic signed      [smao_pkg::DIFF_W-1:0]  angle_change,
	output logic signed      [smao_pkg::SPEED_W-1:0] speed_out,
	output logic                                     reversed
);

	import smao_pkg::*;

	localparam int SUM_W = TOTAL_W + 1;
	localparam int C2_W  = 2 * COS_W - 1;
	localparam int C3_W  = 3 * COS_W - 2;
	localparam int LO_W  = C3_W / 2;
	localparam int HI_W  = C3_W - LO_W;
	localparam int PP_W  = SPEED_W + C3_W - 1;
	localparam int M_SH  = 3 * (COS_W - 1);

	localparam logic signed [SUM_W-1:0] TGT_MAX = SUM_W'({1'b0, {(TOTAL_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] TGT_MIN = -TGT_MAX - SUM_W'(1);
	localparam logic [SPEED_W-1:0]      SPD_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

	// ---------------- stage 7: encoder target, speed magnitude -------------
	logic signed [SUM_W-1:0]   dcode;
	logic signed [SUM_W-1:0]   tsum;
	logic signed [TOTAL_W-1:0] tsat;

	always_comb begin
		dcode = (res.diff < 0) ? -SUM_W'(res.code) : SUM_W'(res.code);
		tsum  = SUM_W'(res.total) + dcode;
		if (tsum > TGT_MAX) begin
			tsat = TOTAL_W'(TGT_MAX);
		end else if (tsum < TGT_MIN) begin
			tsat = TOTAL_W'(TGT_MIN);
		end else begin
			tsat = TOTAL_W'(tsum);
		end
	end

	logic                      v_s7;
	logic signed [TOTAL_W-1:0] target_s7;
	logic signed [DIFF_W-1:0]  diff_s7;
	logic                      rev_s7;
	logic                      neg_s7;
	logic [SPEED_W-1:0]        amag_s7;

	// ---------------- stage 8: cosine squared ------------------------------
	logic                      v_s8;
	logic [C2_W-1:0]           c2_s8;
	logic [COS_W-1:0]          c_s8;
	logic signed [TOTAL_W-1:0] target_s8;
	logic signed [DIFF_W-1:0]  diff_s8;
	logic                      rev_s8;
	logic                      neg_s8;
	logic [SPEED_W-1:0]        amag_s8;

	// ---------------- stage 9: cosine cubed --------------------------------
	logic                      v_s9;
	logic [C3_W-1:0]           c3_s9;
	logic signed [TOTAL_W-1:0] target_s9;
	logic signed [DIFF_W-1:0]  diff_s9;
	logic                      rev_s9;
	logic                      neg_s9;
	logic [SPEED_W-1:0]        amag_s9;

	// ---------------- stage 10: speed times cube, two partial products -----
	logic                      v_s10;
	logic [SPEED_W+LO_W-1:0]   pp_lo_s10;
	logic [SPEED_W+HI_W-1:0]   pp_hi_s10;
	logic signed [TOTAL_W-1:0] target_s10;
	logic signed [DIFF_W-1:0]  diff_s10;
	logic                      rev_s10;
	logic                      neg_s10;

	// ---------------- stage 11: round, sign, saturate ----------------------
	logic [PP_W-1:0]           m_full;
	logic [SPEED_W-1:0]        m;
	logic signed [SPEED_W-1:0] spd_fin;

	always_comb begin
		m_full = (PP_W'(pp_hi_s10) << LO_W) + PP_W'(pp_lo_s10) + (PP_W'(1) << (M_SH - 1));
		m = m_full[M_SH +: SPEED_W];
		if (neg_s10) begin
			spd_fin = SPEED_W'(-(SPEED_W + 1)'(m));
		end else begin
			spd_fin = (m > SPD_MAX) ? SPD_MAX : m;
		end
	end

	logic                      v_s11;
	logic signed [TOTAL_W-1:0] target_s11;
	logic signed [DIFF_W-1:0]  diff_s11;
	logic signed [SPEED_W-1:0] speed_s11;
	logic                      rev_s11;

	// Advance valid bits on enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s7  <= res.valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Advance payload on enable, hold otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			target_s7  <= tsat;
			diff_s7    <= res.diff;
			rev_s7     <= res.rev;
			neg_s7     <= res.spd[SPEED_W-1] ^ res.rev;
			amag_s7    <= (res.spd < 0) ? SPEED_W'(-(SPEED_W + 1)'(res.spd))
			                            : SPEED_W'(res.spd);

			c2_s8      <= C2_W'(C2_W'(cos_val) * C2_W'(cos_val));
			c_s8       <= cos_val;
			target_s8  <= target_s7;
			diff_s8    <= diff_s7;
			rev_s8     <= rev_s7;
			neg_s8     <= neg_s7;
			amag_s8    <= amag_s7;

			c3_s9      <= C3_W'(c2_s8) * C3_W'(c_s8);
			target_s9  <= target_s8;
			diff_s9    <= diff_s8;
			rev_s9     <= rev_s8;
			neg_s9     <= neg_s8;
			amag_s9    <= amag_s8;

			pp_lo_s10  <= (SPEED_W + LO_W)'(amag_s9) * (SPEED_W + LO_W)'(c3_s9[LO_W-1:0]);
			pp_hi_s10  <= (SPEED_W + HI_W)'(amag_s9) * (SPEED_W + HI_W)'(c3_s9[C3_W-1:LO_W]);
			target_s10 <= target_s9;
			diff_s10   <= diff_s9;
			rev_s10    <= rev_s9;
			neg_s10    <= neg_s9;

			target_s11 <= target_s10;
			diff_s11   <= diff_s10;
			speed_s11  <= spd_fin;
			rev_s11    <= rev_s10;
		end
	end

	assign out_valid         = v_s11;
	assign steer_code_target = target_s11;
	assign angle_change      = diff_s11;
	assign speed_out         = speed_s11;
	assign reversed          = rev_s11;

endmodule

`default_nettype wire

// File: dv/swerve_module_angle_optimizer_tb.sv
// Self-checking testbench for the swerve module angle optimizer: directed table, then
// random requests under several steering offsets, each result compared with its typed row or a predictor.
// Depends on smao_pkg and the swerve_module_angle_optimizer RTL.
module swerve_module_angle_optimizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smao_pkg::*;

	localparam longint HALF_PI_Q30 = 1686629713;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint S32_MAX = (64'sd1 << 31) - 1;
	localparam longint S32_MIN = -(64'sd1 << 31);
	localparam longint S16_MAX = 32767;
	localparam longint S16_MIN = -32768;

	localparam int REG_IDX_STEER_OFFSET = 0;
	localparam int REG_IDX_SPARE = 1;
	localparam logic [CFG_AW-1:0] ADDR_STEER_OFFSET = CFG_AW'(4 * REG_IDX_STEER_OFFSET);
	localparam logic [CFG_AW-1:0] ADDR_SPARE = CFG_AW'(4 * REG_IDX_SPARE);

	localparam int N_DIRECTED = 22;
	localparam int N_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int TAIL_CYCLES = 24;

	// Headings around a wheel's present heading that sit on the decision boundaries
	localparam int NEAR_DELTA [12] = '{0, 1, -1, 8999, 9000, 9001, -8999, -9000, -9001,
		17999, 18000, 18001};

	typedef struct {
		logic        [ENC_BITS-1:0] enc;
		logic signed [TOTAL_W-1:0]  total;
		logic signed [TARGET_W-1:0] tgt;
		logic signed [SPEED_W-1:0]  spd;
	} steer_request_t;

	typedef struct {
		logic signed [TOTAL_W-1:0] aim;
		logic signed [DIFF_W-1:0]  turn;
		logic signed [SPEED_W-1:0] drive;
		logic                      rev;
	} steer_result_t;

	typedef struct {
		steer_request_t req;
		bit             typed;
		steer_result_t  res;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [ENC_BITS-1:0] encoder_angle = '0;
	logic signed [TOTAL_W-1:0] encoder_total = '0;
	logic signed [TARGET_W-1:0] target_angle = '0;
	logic signed [SPEED_W-1:0] speed_cmd = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [TOTAL_W-1:0] steer_code_target;
	logic signed [DIFF_W-1:0] angle_change;
	logic signed [SPEED_W-1:0] speed_out;
	logic reversed;

	// Predictor state: steering offset copy and Q1.15 cosine table
	logic [ENC_BITS-1:0] steer_offset_q = '0;
	int cos_q15 [0:COS_TABLE_DEPTH];

	steer_result_t pending_results [$];
	int fail_count = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_reversed = 0;
	int n_target_sat = 0;
	int burst_left = 0;
	bit pressure_req = 1'b0;
	bit hold_active = 1'b0;

	// Directed table; typed rows carry the expected result, the rest use the predictor
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{0, 0, 0, 1000}, 1, '{0, 0, 1000, 0}},
		'{'{0, 12345, 18000, -32768}, 1, '{12345, 0, 32767, 1}},
		'{'{4096, -500, 0, 500}, 1, '{-500, 0, -500, 1}},
		'{'{0, 32'sh7fffffff, 9000, 0}, 1, '{32'sh7fffffff, 9000, 0, 0}},
		'{'{0, 32'sh80000000, -9000, 0}, 1, '{32'sh80000000, -9000, 0, 0}},
		'{'{0, 0, 36000, 1000}, 1, '{0, 0, 1000, 0}},
		'{'{0, 0, -36000, -1000}, 1, '{0, 0, -1000, 0}},
		'{'{6144, 0, 9000, 777}, 1, '{0, 0, -777, 1}},
		'{'{0, 100, 9000, 32767}, 0, '{0, 0, 0, 0}},
		'{'{0, 100, -9000, -32768}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 9001, 1000}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 8999, 1000}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 26999, 1000}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 65535, 2000}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, -65536, -2000}, 0, '{0, 0, 0, 0}},
		'{'{8191, 0, 0, 1}, 0, '{0, 0, 0, 0}},
		'{'{8191, 2147483000, 35999, -1}, 0, '{0, 0, 0, 0}},
		'{'{4095, 0, 17999, 32767}, 0, '{0, 0, 0, 0}},
		'{'{4097, -2147483000, 0, -32768}, 0, '{0, 0, 0, 0}},
		'{'{1, 7, 18001, 12345}, 0, '{0, 0, 0, 0}},
		'{'{2048, 0, 27000, 3000}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 4500, -32768}, 0, '{0, 0, 0, 0}}
	};

	swerve_module_angle_optimizer u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.encoder_angle    (encoder_angle),
		.encoder_total    (encoder_total),
		.target_angle     (target_angle),
		.speed_cmd        (speed_cmd),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.steer_code_target(steer_code_target),
		.angle_change     (angle_change),
		.speed_out        (speed_out),
		.reversed         (reversed)
	);

	always #4 clk = ~clk;

	function automatic longint wrap_mod(longint a, longint m);
		longint r;
		r = a % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	// Build the cosine table: Taylor series to x^14 in Q30, rounded to Q1.15
	function automatic void fill_cosine_table();
		longint x, x2, term, acc;
		for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
			x = (longint'(i) * HALF_PI_Q30 + COS_TABLE_DEPTH / 2) / COS_TABLE_DEPTH;
			x2 = (x * x) >>> 30;
			term = ONE_Q30;
			acc = ONE_Q30;
			for (int k = 1; k <= 7; k++) begin
				term = (term * x2) / ONE_Q30;
				term = -(term / ((2 * k - 1) * (2 * k)));
				acc += term;
			end
			if (acc < 0)
				acc = 0;
			cos_q15[i] = int'((acc + (64'sd1 << 14)) >>> 15);
		end
	endfunction

	// Present heading in hundredths of a degree from the single-turn encoder
	function automatic longint heading_centi(logic [ENC_BITS-1:0] enc);
		longint d, cur;
		d = wrap_mod(longint'(enc) - longint'(steer_offset_q), ENCODER_COUNTS);
		cur = (d * TURN_CENTI + ENCODER_COUNTS / 2) / ENCODER_COUNTS;
		if (cur >= TURN_CENTI)
			cur = 0;
		return cur;
	endfunction

	// Shortest rotation with reversal, encoder target and cosine-cubed wheel speed
	function automatic steer_result_t predict_module(steer_request_t r);
		longint cur, aim_heading, cw, ccw, diff, flipped, mag, code, aim, idx, c, spd_mag, s;
		bit rev;
		steer_result_t res;
		cur = heading_centi(r.enc);
		aim_heading = wrap_mod(longint'(r.tgt), TURN_CENTI);
		cw = wrap_mod(aim_heading - cur, TURN_CENTI);
		ccw = TURN_CENTI - cw;
		diff = (ccw < cw) ? -ccw : cw;
		rev = 1'b0;
		// turn to the opposite heading and reverse the drive past a quarter turn
		if (diff > QUARTER_TURN_CENTI || diff < -QUARTER_TURN_CENTI) begin
			flipped = wrap_mod(cur + HALF_TURN_CENTI, TURN_CENTI);
			if (cw > ccw)
				diff = wrap_mod(aim_heading - flipped, TURN_CENTI);
			else
				diff = -wrap_mod(flipped - aim_heading, TURN_CENTI);
			rev = 1'b1;
		end
		mag = (diff < 0) ? -diff : diff;
		code = (mag * ENCODER_COUNTS + HALF_TURN_CENTI) / TURN_CENTI;
		if (diff < 0)
			code = -code;
		aim = longint'(r.total) + code;
		if (aim > S32_MAX)
			aim = S32_MAX;
		if (aim < S32_MIN)
			aim = S32_MIN;
		idx = (mag * COS_TABLE_DEPTH + QUARTER_TURN_CENTI / 2) / QUARTER_TURN_CENTI;
		if (idx > COS_TABLE_DEPTH)
			idx = COS_TABLE_DEPTH;
		c = cos_q15[idx];
		spd_mag = (r.spd < 0) ? -longint'(r.spd) : longint'(r.spd);
		s = (spd_mag * c * c * c + (64'sd1 << 44)) >>> 45;
		if ((r.spd < 0) != rev)
			s = -s;
		if (s > S16_MAX)
			s = S16_MAX;
		if (s < S16_MIN)
			s = S16_MIN;
		res.aim = TOTAL_W'(aim);
		res.turn = DIFF_W'(diff);
		res.drive = SPEED_W'(s);
		res.rev = rev;
		return res;
	endfunction

	// Draw a random request; many targets land near the reversal and quarter-turn boundaries
	function automatic steer_request_t draw_request();
		steer_request_t r;
		longint aim;
		int pick, k;
		r.enc = ENC_BITS'($urandom);
		r.total = TOTAL_W'($urandom);
		pick = $urandom_range(0, 15);
		if (pick == 0)
			r.total = TOTAL_W'(S32_MAX - longint'($urandom_range(0, 4095)));
		else if (pick == 1)
			r.total = TOTAL_W'(S32_MIN + longint'($urandom_range(0, 4095)));
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			r.tgt = TARGET_W'(int'($urandom_range(0, 72000)) - 36000);
		end else if (pick == 4) begin
			r.tgt = TARGET_W'($urandom);
		end else if (pick < 9) begin
			aim = heading_centi(r.enc) + NEAR_DELTA[$urandom_range(0, 11)];
			if (pick == 8)
				aim += int'($urandom_range(0, 40)) - 20;
			k = int'($urandom_range(0, 2)) - 1;
			if (aim + k * TURN_CENTI <= 65535 && aim + k * TURN_CENTI >= -65536)
				aim += k * TURN_CENTI;
			r.tgt = TARGET_W'(aim);
		end else begin
			r.tgt = TARGET_W'((int'($urandom_range(0, 8)) - 4) * QUARTER_TURN_CENTI);
		end
		r.spd = SPEED_W'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 4))
				0: r.spd = 16'sh7fff;
				1: r.spd = 16'sh8000;
				2: r.spd = 16'sd1;
				3: r.spd = -16'sd1;
				default: r.spd = '0;
			endcase
		end
		return r;
	endfunction

	task automatic check_field(string fname, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", fname, want, got);
			fail_count++;
		end
	endtask

	task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_STEER_OFFSET)
			steer_offset_q = data[ENC_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic cfg_read_check(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("steer_offset readback: expected %0d, got %0d", want, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Insert a random gap at the end of each burst; hold the request stream during a hold-off
	task automatic sender_pause();
		int gap;
		if (burst_left == 0 && !hold_active) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		if (burst_left > 0)
			burst_left--;
	endtask

	// Offer one request, wait for it to be taken, then record its expected result
	task automatic offer_request(steer_request_t r, bit typed, steer_result_t typed_res);
		in_valid <= 1'b1;
		encoder_angle <= r.enc;
		encoder_total <= r.total;
		target_angle <= r.tgt;
		speed_cmd <= r.spd;
		do @(posedge clk); while (in_stall);
		if (typed)
			pending_results.push_back(typed_res);
		else
			pending_results.push_back(predict_module(r));
		n_accepted++;
	endtask

	// Drop valid and wait until every outstanding result has been checked
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stall pattern: runs of random density, plus one long hold-off
	initial begin : stall_gen
		int run_len, pct;
		bit held;
		held = 1'b0;
		forever begin
			run_len = $urandom_range(4, 60);
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 20;
				2: pct = 50;
				default: pct = 80;
			endcase
			repeat (run_len) begin
				@(posedge clk);
				if (pressure_req && !held) begin
					hold_active = 1'b1;
					out_stall <= 1'b1;
					for (int n = 0; n < HOLD_OFF_CYCLES; n++)
						@(posedge clk);
					held = 1'b1;
					hold_active = 1'b0;
				end
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		steer_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("steer_code_target", want.aim, steer_code_target);
				check_field("angle_change", want.turn, angle_change);
				check_field("speed_out", want.drive, speed_out);
				check_field("reversed", want.rev, reversed);
				n_checked++;
				if (reversed)
					n_reversed++;
				if (steer_code_target == 32'sh7fffffff || steer_code_target == 32'sh80000000)
					n_target_sat++;
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("timeout: requests or results stopped moving");
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main_seq
		logic [CFG_DW-1:0] offset_word;
		steer_result_t none;
		none = '{0, 0, 0, 0};
		fill_cosine_table();

		// Hold reset, then confirm the offset register comes up at zero
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		cfg_read_check(ADDR_STEER_OFFSET, '0);

		// Walk the directed table at the reset offset
		for (int i = 0; i < N_DIRECTED; i++) begin
			sender_pause();
			offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
		end

		// Random phases, each under its own steering offset
		for (int p = 0; p < N_PHASES; p++) begin
			wait_for_drain();
			case (p)
				0: offset_word = 32'd8191;
				1: offset_word = $urandom;
				2: offset_word = 32'd1;
				3: offset_word = 32'd4096;
				4: offset_word = $urandom;
				default: offset_word = '0;
			endcase
			cfg_write(ADDR_STEER_OFFSET, offset_word);
			// a write to the unused address must leave the offset alone
			if (p == 3)
				cfg_write(ADDR_SPARE, ~offset_word);
			cfg_read_check(ADDR_STEER_OFFSET, CFG_DW'(steer_offset_q));
			if (p == 0)
				pressure_req = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				sender_pause();
				offer_request(draw_request(), 1'b0, none);
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests (%0d directed) over %0d steering offsets.",
			n_accepted, N_DIRECTED, N_PHASES + 1);
		$display("Checked %0d results: %0d reversed, %0d with a saturated encoder target.",
			n_checked, n_reversed, n_target_sat);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
design/smao_pkg.sv
design/smao_ram.sv
design/smao_cos_init.sv
design/smao_angle_pipe.sv
design/smao_out_pipe.sv
design/swerve_module_angle_optimizer.sv
dv/swerve_module_angle_optimizer_tb.sv
